### rtl/wpsc_pkg.sv
// Shared types and constants for the wheel period PI speed controller.
// Used by every module in rtl/; depends on nothing.
package wpsc_pkg;

  localparam int WHEEL_COUNT_DEF = 4;

  localparam int WHEEL_W   = 2;
  localparam int TS_W      = 32;
  localparam int SPD_W     = 24;
  localparam int DRV_W     = 32;
  localparam int ERR_W     = SPD_W + 1;
  localparam int INTEG_W   = 56;
  localparam int GAIN_W    = 16;
  localparam int SHIFT_W   = 6;
  localparam int NUM_W     = 28;
  localparam int TCLAMP_W  = 49;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int SEEN_W    = 2;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  localparam int QUEUE_DEPTH = 2;

  // 1e6 microseconds per second times 256 for the Q16.8 result
  localparam logic [NUM_W-1:0] SPEED_NUM = 28'd256000000;
  localparam logic [SPD_W-1:0] SPEED_MAX = 24'hFFFFFF;
  localparam logic [SEEN_W-1:0] EDGES_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_SHIFT = 2'd2;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd2560;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd1280;
  localparam logic [SHIFT_W-1:0] INTEG_SHIFT_RST = 6'd20;

  localparam logic FUNC_PULSE  = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [SHIFT_W-1:0] integ_shift;
  } cfg_t;

  // one speed update request waiting for the back end
  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic [TS_W-1:0]    interval;
    logic [SPD_W-1:0]   target;
  } upd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

### rtl/wheel_period_pi_speed_control_top.sv
// Top level of the wheel period PI speed controller: stream ports,
// configuration registers, front end, queue and back end. Depends on wpsc_pkg.
//
// Encoder pulse items (tuser 0) only update the wheel's pulse times;
// update items (tuser 1) go through a two-entry queue to the back end,
// which runs a bit-serial 28-step speed divide (skipped when the interval
// is zero) followed by eight steps of PI arithmetic whose multiplies share
// one multiplier. Pulses keep flowing while the back end works as long as
// the queue has room; with two updates waiting, all input stalls until the
// back end takes one. A finished result waits in the output register while
// the next update starts. Each update for a wheel below WHEEL_COUNT yields
// one result; pulses and updates for other wheels yield none. Configuration
// is written through the cfg_ port (index 0 prop_gain, 1 integ_gain, 2
// integ_shift); the user must write it only while no update is in flight,
// which the block itself does not enforce; it is always ready.
module wheel_period_pi_speed_control_top #(
  parameter int WHEEL_COUNT = wpsc_pkg::WHEEL_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [1:0] wheel, [33:2] timestamp_us, [57:34] target_speed, [63:58] zero
  input  logic [wpsc_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [0] func
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [1:0] out_wheel, [33:2] drive, [57:34] measured_speed, [63:58] zero
  output logic [wpsc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wpsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wpsc_pkg::CFG_DAT_W-1:0]        cfg_data
);

  wpsc_pkg::cfg_t    cfg_r;
  wpsc_pkg::upd_t    q_in;
  wpsc_pkg::upd_t    q_out;
  wpsc_pkg::q_stat_t q_stat;
  logic              q_push;
  logic              q_pop;

  logic [wpsc_pkg::WHEEL_W-1:0]      res_wheel;
  logic signed [wpsc_pkg::DRV_W-1:0] res_drive;
  logic [wpsc_pkg::SPD_W-1:0]        res_speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= wpsc_pkg::PROP_GAIN_RST;
      cfg_r.integ_gain  <= wpsc_pkg::INTEG_GAIN_RST;
      cfg_r.integ_shift <= wpsc_pkg::INTEG_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wpsc_pkg::CFG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_data;
        wpsc_pkg::CFG_INTEG_GAIN:  cfg_r.integ_gain  <= cfg_data;
        wpsc_pkg::CFG_INTEG_SHIFT: cfg_r.integ_shift <= cfg_data[wpsc_pkg::SHIFT_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  wpsc_front #(
    .WHEEL_COUNT(WHEEL_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_func         (in_tuser),
    .in_wheel        (in_tdata[1:0]),
    .in_timestamp_us (in_tdata[33:2]),
    .in_target_speed (in_tdata[57:34]),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  wpsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  wpsc_back #(
    .WHEEL_COUNT(WHEEL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_data    (q_out),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_wheel (res_wheel),
    .out_drive (res_drive),
    .out_speed (res_speed)
  );

  assign out_tdata = {6'b0, res_speed, res_drive, res_wheel};

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("request pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("request popped from an empty queue");

  a_pop_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end took two requests in consecutive cycles");
`endif

endmodule

### rtl/wpsc_queue.sv
// Small request queue between the front end and the PI back end.
// Depends on wpsc_pkg.
module wpsc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wpsc_pkg::upd_t     push_data,
  input  logic               pop,
  output wpsc_pkg::upd_t     pop_data,
  output wpsc_pkg::q_stat_t  stat
);

  localparam int DEPTH = wpsc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wpsc_pkg::upd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));

endmodule

### rtl/wpsc_front.sv
// Front end: takes input items, keeps per-wheel encoder times and turns
// update requests into interval records for the queue. Depends on wpsc_pkg.
module wpsc_front #(
  parameter int WHEEL_COUNT = wpsc_pkg::WHEEL_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [wpsc_pkg::WHEEL_W-1:0]  in_wheel,
  input  logic [wpsc_pkg::TS_W-1:0]     in_timestamp_us,
  input  logic [wpsc_pkg::SPD_W-1:0]    in_target_speed,
  input  wpsc_pkg::q_stat_t             q_stat,
  output logic                          q_push,
  output wpsc_pkg::upd_t                q_data
);

  localparam int IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
  localparam int EXT_W = IDX_W + wpsc_pkg::WHEEL_W;

  logic [wpsc_pkg::TS_W-1:0]   last_r  [WHEEL_COUNT];
  logic [wpsc_pkg::TS_W-1:0]   prior_r [WHEEL_COUNT];
  logic [wpsc_pkg::SEEN_W-1:0] seen_r  [WHEEL_COUNT];

  logic [EXT_W-1:0] wheel_ext;
  logic [IDX_W-1:0] idx;
  logic             wheel_ok;
  logic             accept;
  logic             pulse_wr;

  assign wheel_ext = EXT_W'(in_wheel);
  assign idx       = wheel_ext[IDX_W-1:0];
  assign wheel_ok  = (wheel_ext < EXT_W'(WHEEL_COUNT));

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign pulse_wr = accept && wheel_ok && (in_func == wpsc_pkg::FUNC_PULSE);
  assign q_push   = accept && wheel_ok && (in_func == wpsc_pkg::FUNC_UPDATE);

  // interval counts as zero until two pulses are on record
  always_comb begin
    q_data.wheel    = in_wheel;
    q_data.target   = in_target_speed;
    q_data.interval = '0;
    if (wheel_ok && seen_r[idx] == wpsc_pkg::EDGES_FULL) begin
      q_data.interval = last_r[idx] - prior_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        last_r[i]  <= '0;
        prior_r[i] <= '0;
        seen_r[i]  <= '0;
      end
    end else if (pulse_wr) begin
      prior_r[idx] <= last_r[idx];
      last_r[idx]  <= in_timestamp_us;
      if (seen_r[idx] != wpsc_pkg::EDGES_FULL) begin
        seen_r[idx] <= seen_r[idx] + wpsc_pkg::SEEN_W'(1);
      end
    end
  end

endmodule

### rtl/wpsc_back.sv
// Back end: divides for speed, runs the PI arithmetic on one shared
// multiplier and holds the result register. Depends on wpsc_pkg.
module wpsc_back #(
  parameter int WHEEL_COUNT = wpsc_pkg::WHEEL_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wpsc_pkg::cfg_t                     cfg,
  input  wpsc_pkg::upd_t                     q_data,
  input  wpsc_pkg::q_stat_t                  q_stat,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wpsc_pkg::WHEEL_W-1:0]       out_wheel,
  output logic signed [wpsc_pkg::DRV_W-1:0]  out_drive,
  output logic [wpsc_pkg::SPD_W-1:0]         out_speed
);

  localparam int IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;
  localparam int EXT_W = IDX_W + wpsc_pkg::WHEEL_W;
  localparam int CNT_W = $clog2(wpsc_pkg::NUM_W);
  localparam int IW    = wpsc_pkg::INTEG_W;
  localparam int TW    = wpsc_pkg::TCLAMP_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_ERR  = 4'd2;
  localparam logic [3:0] S_MI   = 4'd3;
  localparam logic [3:0] S_MP   = 4'd4;
  localparam logic [3:0] S_SH   = 4'd5;
  localparam logic [3:0] S_ML   = 4'd6;
  localparam logic [3:0] S_MH   = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_DRV  = 4'd9;

  localparam logic signed [IW-1:0] TLIM_HI = 56'sd140737488355328;
  localparam logic signed [IW-1:0] TLIM_LO = -56'sd140737488355328;

  logic [3:0]                        state_r, state_nxt;
  logic [CNT_W-1:0]                  cnt_r;
  logic [wpsc_pkg::WHEEL_W-1:0]      wheel_r;
  logic [wpsc_pkg::TS_W-1:0]         intv_r;
  logic [wpsc_pkg::SPD_W-1:0]        tgt_r;
  logic [wpsc_pkg::SPD_W-1:0]        speed_r;
  logic [wpsc_pkg::NUM_W-1:0]        quo_r;
  logic [wpsc_pkg::TS_W-1:0]         rem_r;
  logic signed [wpsc_pkg::ERR_W-1:0] err_r;
  logic signed [57:0]                prod_r;
  logic signed [IW-1:0]              integ_r;
  logic signed [33:0]                pterm_r;
  logic signed [TW-1:0]              t_r;
  logic [39:0]                       lo_r;
  logic signed [65:0]                full_r;
  logic signed [IW-1:0]              integ_mem_r [WHEEL_COUNT];

  logic                              out_valid_r;
  logic [wpsc_pkg::WHEEL_W-1:0]      out_wheel_r;
  logic signed [wpsc_pkg::DRV_W-1:0] out_drive_r;
  logic [wpsc_pkg::SPD_W-1:0]        out_speed_r;

  logic [EXT_W-1:0]                  wheel_ext;
  logic [IDX_W-1:0]                  idx;
  logic [wpsc_pkg::TS_W:0]           rem_sh;
  logic                              rem_ge;
  logic [wpsc_pkg::TS_W:0]           rem_sub;
  logic [wpsc_pkg::SPD_W-1:0]        speed_sat;
  logic signed [32:0]                mul_a;
  logic signed [24:0]                mul_b;
  logic signed [57:0]                mul_p;
  logic signed [58:0]                isum;
  logic signed [IW-1:0]              integ_sat;
  logic signed [IW-1:0]              t_sh;
  logic signed [TW-1:0]              t_clamp;
  logic signed [65:0]                hi_ext;
  logic signed [57:0]                iterm;
  logic signed [58:0]                dsum;
  logic signed [wpsc_pkg::DRV_W-1:0] drive_sat;
  logic                              out_free;

  assign wheel_ext = EXT_W'(wheel_r);
  assign idx       = wheel_ext[IDX_W-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && !q_stat.empty;

  // restoring divide, one quotient bit per cycle; quotient shifts in
  // behind the numerator bits
  assign rem_sh  = {rem_r, quo_r[wpsc_pkg::NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, intv_r});
  assign rem_sub = rem_sh - {1'b0, intv_r};

  assign speed_sat = (quo_r > wpsc_pkg::NUM_W'(wpsc_pkg::SPEED_MAX)) ?
                     wpsc_pkg::SPEED_MAX : quo_r[wpsc_pkg::SPD_W-1:0];

  // one shared multiplier, operands chosen by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MI: begin
        mul_a = $signed({1'b0, intv_r});
        mul_b = err_r;
      end
      S_MP: begin
        mul_a = $signed({17'b0, cfg.prop_gain});
        mul_b = err_r;
      end
      S_ML: begin
        mul_a = $signed({17'b0, cfg.integ_gain});
        mul_b = $signed({1'b0, t_r[23:0]});
      end
      S_MH: begin
        mul_a = $signed({17'b0, cfg.integ_gain});
        mul_b = t_r[TW-1:24];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // saturating integral update
  assign isum = $signed({{3{integ_mem_r[idx][IW-1]}}, integ_mem_r[idx]}) +
                $signed({prod_r[57], prod_r});
  always_comb begin
    if (isum[58:IW-1] == {4{isum[IW-1]}}) begin
      integ_sat = isum[IW-1:0];
    end else if (isum[58]) begin
      integ_sat = $signed({1'b1, {(IW-1){1'b0}}});
    end else begin
      integ_sat = $signed({1'b0, {(IW-1){1'b1}}});
    end
  end

  assign t_sh = integ_r >>> cfg.integ_shift;
  always_comb begin
    if (t_sh > TLIM_HI) begin
      t_clamp = TLIM_HI[TW-1:0];
    end else if (t_sh < TLIM_LO) begin
      t_clamp = TLIM_LO[TW-1:0];
    end else begin
      t_clamp = t_sh[TW-1:0];
    end
  end

  assign hi_ext = $signed({{24{prod_r[41]}}, prod_r[41:0]});
  assign iterm  = full_r[65:8];
  assign dsum   = $signed({iterm[57], iterm}) + $signed({{25{pterm_r[33]}}, pterm_r});
  always_comb begin
    if (dsum[58:31] == {28{dsum[31]}}) begin
      drive_sat = dsum[31:0];
    end else if (dsum[58]) begin
      drive_sat = $signed({1'b1, 31'b0});
    end else begin
      drive_sat = $signed({1'b0, {31{1'b1}}});
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = (q_data.interval == '0) ? S_ERR : S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR: state_nxt = S_MI;
      S_MI:  state_nxt = S_MP;
      S_MP:  state_nxt = S_SH;
      S_SH:  state_nxt = S_ML;
      S_ML:  state_nxt = S_MH;
      S_MH:  state_nxt = S_SUM;
      S_SUM: state_nxt = S_DRV;
      S_DRV: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        integ_mem_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DRV && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_MP) begin
        integ_mem_r[idx] <= integ_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        wheel_r <= q_data.wheel;
        intv_r  <= q_data.interval;
        tgt_r   <= q_data.target;
        rem_r   <= '0;
        cnt_r   <= CNT_W'(wpsc_pkg::NUM_W - 1);
        quo_r   <= (q_data.interval == '0) ? '0 : wpsc_pkg::SPEED_NUM;
      end
      S_DIV: begin
        rem_r <= rem_ge ? rem_sub[wpsc_pkg::TS_W-1:0] : rem_sh[wpsc_pkg::TS_W-1:0];
        quo_r <= {quo_r[wpsc_pkg::NUM_W-2:0], rem_ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_ERR: begin
        speed_r <= speed_sat;
        err_r   <= $signed({1'b0, tgt_r}) - $signed({1'b0, speed_sat});
      end
      S_MI: prod_r <= mul_p;
      S_MP: begin
        prod_r  <= mul_p;
        integ_r <= integ_sat;
      end
      S_SH: begin
        pterm_r <= prod_r[41:8];
        t_r     <= t_clamp;
      end
      S_ML: prod_r <= mul_p;
      S_MH: begin
        lo_r   <= prod_r[39:0];
        prod_r <= mul_p;
      end
      S_SUM: full_r <= (hi_ext <<< 24) + $signed({26'b0, lo_r});
      S_DRV: begin
        if (out_free) begin
          out_wheel_r <= wheel_r;
          out_drive_r <= drive_sat;
          out_speed_r <= speed_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_wheel = out_wheel_r;
  assign out_drive = out_drive_r;
  assign out_speed = out_speed_r;

endmodule
